@@ design/ssih_pkg.sv @@
// ssih_pkg: request codes, register map and controller/datapath link types
// for the subsampled image histogram.
// No dependencies; used by every other design file.
package ssih_pkg;

  typedef enum logic [1:0] {
    REQ_PIXEL = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

  // pixel_format codes; anything but gray8 selects bits 15:8
  localparam logic [1:0] FMT_GRAY8  = 2'd0;
  localparam logic [1:0] FMT_GRAY16 = 2'd1;
  localparam logic [1:0] FMT_RGB    = 2'd2;

  // register map: word index taken from paddr[2]
  localparam logic REG_PIXEL_FORMAT = 1'b0;

  localparam int REQ_W   = 2;
  localparam int PIXEL_W = 24;
  localparam int INDEX_W = 8;
  localparam int OUT_W   = 32;

  typedef struct packed {
    logic accept;      // input beat taken this cycle
    logic update_wr;   // write back incremented bin
    logic load_out;    // load output register
    logic clear_step;  // zero one bin of the clearing pass
  } ssih_cmd_t;

  typedef struct packed {
    logic sample_hit;  // current pixel lands on the subsample grid
    logic clear_done;  // clearing pass is on its last bin
  } ssih_sts_t;

endpackage

@@ design/ssih_if.sv @@
// ssih_if: valid/ready channel interfaces for request and result beats.
// Depends on ssih_pkg for field widths.
interface ssih_in_if;
  logic                             valid;
  logic                             ready;
  logic [ssih_pkg::REQ_W-1:0]       req_type;
  logic [ssih_pkg::PIXEL_W-1:0]     pixel_value;
  logic                             last_in_row;
  logic [ssih_pkg::INDEX_W-1:0]     bin_index;

  modport source (output valid, req_type, pixel_value, last_in_row, bin_index,
                  input ready);
  modport sink   (input valid, req_type, pixel_value, last_in_row, bin_index,
                  output ready);
endinterface

interface ssih_out_if;
  logic                         valid;
  logic                         ready;
  logic [ssih_pkg::OUT_W-1:0]   bin_count;
  logic [ssih_pkg::OUT_W-1:0]   sample_total;
  logic                         has_data;

  modport source (output valid, bin_count, sample_total, has_data, input ready);
  modport sink   (input valid, bin_count, sample_total, has_data, output ready);
endinterface

@@ design/ssih_ctrl.sv @@
// ssih_ctrl: sequencing state machine (clear pass, read-modify-write, response).
// Depends on ssih_pkg for request codes and link structs.
module ssih_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ssih_pkg::REQ_W-1:0] req_type,
  output logic                       out_valid,
  input  logic                       out_ready,
  input  ssih_pkg::ssih_sts_t        sts,
  output ssih_pkg::ssih_cmd_t        cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_RESPOND
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd            = '0;
    cmd.accept     = in_valid && in_ready;
    cmd.update_wr  = (state == ST_UPDATE);
    cmd.clear_step = (state == ST_CLEAR);
    cmd.load_out   = (state == ST_RESPOND) && out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:   if (sts.clear_done) state_next = ST_IDLE;
      ST_IDLE: begin
        if (cmd.accept) begin
          priority case (req_type)
            ssih_pkg::REQ_PIXEL: state_next = sts.sample_hit ? ST_UPDATE : ST_IDLE;
            ssih_pkg::REQ_READ:  state_next = ST_RESPOND;
            ssih_pkg::REQ_CLEAR: state_next = ST_CLEAR;
            default:             state_next = ST_IDLE;
          endcase
        end
      end
      ST_UPDATE:  state_next = ST_IDLE;
      ST_RESPOND: if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ design/ssih_datapath.sv @@
// ssih_datapath: bin memory, subsample phase counters, sample total and
// output register. Driven by ssih_ctrl commands; depends on ssih_pkg.
module ssih_datapath #(
  parameter int BIN_COUNT      = 256,
  parameter int SUBSAMPLE_STEP = 4,
  parameter int COUNT_BITS     = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ssih_pkg::ssih_cmd_t          cmd,
  output ssih_pkg::ssih_sts_t          sts,
  input  logic [1:0]                   pixel_format,
  input  logic [ssih_pkg::REQ_W-1:0]   req_type,
  input  logic [ssih_pkg::PIXEL_W-1:0] pixel_value,
  input  logic                         last_in_row,
  input  logic [ssih_pkg::INDEX_W-1:0] bin_index,
  output logic [ssih_pkg::OUT_W-1:0]   bin_count,
  output logic [ssih_pkg::OUT_W-1:0]   sample_total,
  output logic                         has_data
);

  localparam int ADDR_W  = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int PHASE_W = (SUBSAMPLE_STEP > 1) ? $clog2(SUBSAMPLE_STEP) : 1;
  localparam int MUL_W   = 8 + $clog2(BIN_COUNT + 1);
  localparam int IDX_W   = ssih_pkg::INDEX_W + ADDR_W;
  localparam int EXT_W   = (COUNT_BITS > ssih_pkg::OUT_W) ? COUNT_BITS : ssih_pkg::OUT_W;

  logic [COUNT_BITS-1:0] mem [BIN_COUNT];
  logic [COUNT_BITS-1:0] rdata;
  logic [ADDR_W-1:0]     wr_addr;
  logic                  idx_out_of_range;

  logic [PHASE_W-1:0]    column_phase;
  logic [PHASE_W-1:0]    row_phase;
  logic [COUNT_BITS-1:0] counted_total;
  logic                  data_seen;
  logic [ADDR_W-1:0]     clr_addr;

  logic [7:0]            bright;
  logic [MUL_W-1:0]      bin_prod;
  logic [ADDR_W-1:0]     pix_bin;
  logic [IDX_W-1:0]      idx_ext;
  logic                  idx_in_range;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  is_pixel;
  logic                  hit;
  logic [PHASE_W-1:0]    column_next;
  logic [PHASE_W-1:0]    row_next;
  logic [EXT_W-1:0]      bin_ext;
  logic [EXT_W-1:0]      total_ext;

  function automatic logic [PHASE_W-1:0] step_phase(input logic [PHASE_W-1:0] p);
    logic [PHASE_W:0] n;
    n = {1'b0, p} + (PHASE_W + 1)'(1);
    return (n >= (PHASE_W + 1)'(SUBSAMPLE_STEP)) ? '0 : n[PHASE_W-1:0];
  endfunction

  // bin = byte * BIN_COUNT / 256, a constant multiply and a shift
  assign bright   = (pixel_format == ssih_pkg::FMT_GRAY8) ? pixel_value[7:0]
                                                          : pixel_value[15:8];
  assign bin_prod = MUL_W'(bright) * MUL_W'(BIN_COUNT);
  assign pix_bin  = bin_prod[8 +: ADDR_W];

  assign idx_ext      = IDX_W'(bin_index);
  assign idx_in_range = idx_ext < IDX_W'(BIN_COUNT);

  assign is_pixel = (req_type == ssih_pkg::REQ_PIXEL);
  assign rd_addr  = is_pixel ? pix_bin : idx_ext[ADDR_W-1:0];
  assign hit      = (column_phase == '0) && (row_phase == '0);

  assign column_next = last_in_row ? '0 : step_phase(column_phase);
  assign row_next    = last_in_row ? step_phase(row_phase) : row_phase;

  assign sts.sample_hit = hit;
  assign sts.clear_done = (clr_addr == ADDR_W'(BIN_COUNT - 1));

  // single-port bin store; read at accept, write back in the next cycle
  always_ff @(posedge clk) begin
    if (cmd.update_wr) begin
      mem[wr_addr] <= (&rdata) ? rdata : rdata + COUNT_BITS'(1);
    end else if (cmd.clear_step) begin
      mem[clr_addr] <= '0;
    end
    if (cmd.accept) begin
      rdata            <= mem[rd_addr];
      wr_addr          <= pix_bin;
      idx_out_of_range <= !idx_in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_phase  <= '0;
      row_phase     <= '0;
      counted_total <= '0;
      data_seen     <= 1'b0;
      clr_addr      <= '0;
    end else begin
      if (cmd.clear_step && !sts.clear_done) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (cmd.accept) begin
        priority case (req_type)
          ssih_pkg::REQ_PIXEL: begin
            column_phase <= column_next;
            row_phase    <= row_next;
            if (hit) begin
              if (!(&counted_total)) begin
                counted_total <= counted_total + COUNT_BITS'(1);
              end
              data_seen <= 1'b1;
            end
          end
          ssih_pkg::REQ_CLEAR: begin
            column_phase  <= '0;
            row_phase     <= '0;
            counted_total <= '0;
            data_seen     <= 1'b0;
            clr_addr      <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  assign bin_ext   = EXT_W'(rdata);
  assign total_ext = EXT_W'(counted_total);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (idx_out_of_range) begin
        bin_count <= '0;
      end else if (bin_ext > EXT_W'(32'hFFFF_FFFF)) begin
        bin_count <= 32'hFFFF_FFFF;
      end else begin
        bin_count <= bin_ext[ssih_pkg::OUT_W-1:0];
      end
      sample_total <= (total_ext > EXT_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                         : total_ext[ssih_pkg::OUT_W-1:0];
      has_data     <= data_seen;
    end
  end

endmodule

@@ design/subsampled_image_histogram.sv @@
// Pixel: off the subsample grid, only the phase counters step; on it, the bin is read, then
// written back through the single-port bin memory. Read: the bin is read into a holding
// register, then loaded into the output register once the output is free. A read arriving while
// a result waits is taken and holds the input until it goes. Clear request and reset: a clearing
// pass over all BIN_COUNT bins, one bin a cycle, with no request beats taken. pixel_format resets
// to gray8 and survives a clear request. Depends on ssih_pkg, ssih_if, ssih_ctrl and ssih_datapath.
module subsampled_image_histogram #(
  parameter int BIN_COUNT      = 256,
  parameter int SUBSAMPLE_STEP = 4,
  parameter int COUNT_BITS     = 32
) (
  input  logic        clk,
  input  logic        rst,
  ssih_in_if.sink     sample_in,
  ssih_out_if.source  result_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                pixel_format_reg;
  logic [1:0]          pixel_format;
  ssih_pkg::ssih_cmd_t cmd;
  ssih_pkg::ssih_sts_t sts;

  assign pixel_format_reg = (paddr[2] == ssih_pkg::REG_PIXEL_FORMAT);
  assign pready = 1'b1;
  assign prdata = pixel_format_reg ? {30'd0, pixel_format} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= ssih_pkg::FMT_GRAY8;
    end else if (psel && penable && pwrite && pready && pixel_format_reg) begin
      pixel_format <= pwdata[1:0];
    end
  end

  ssih_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample_in.valid),
    .in_ready  (sample_in.ready),
    .req_type  (sample_in.req_type),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ssih_datapath #(
    .BIN_COUNT      (BIN_COUNT),
    .SUBSAMPLE_STEP (SUBSAMPLE_STEP),
    .COUNT_BITS     (COUNT_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .pixel_format (pixel_format),
    .req_type     (sample_in.req_type),
    .pixel_value  (sample_in.pixel_value),
    .last_in_row  (sample_in.last_in_row),
    .bin_index    (sample_in.bin_index),
    .bin_count    (result_out.bin_count),
    .sample_total (result_out.sample_total),
    .has_data     (result_out.has_data)
  );

endmodule

@@ design/ssih_check.sv @@
// ssih_check: port-level checks on the histogram top level, bound in below.
// Depends on ssih_pkg for request codes.
module ssih_check (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [ssih_pkg::REQ_W-1:0] req_type,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ssih_pkg::OUT_W-1:0] sample_total,
  input logic                       has_data
);

  // a result beat waiting on the sink holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_total))
    else $error("result beat dropped or changed while stalled");

  // clearing pass follows reset: nothing taken, nothing offered
  a_reset_clear: assert property (@(posedge clk)
    $fell(rst) |-> !in_ready && !out_valid)
    else $error("block active right after reset");

  // a clear request starts the clearing pass
  a_clear_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && req_type == ssih_pkg::REQ_CLEAR |=> !in_ready)
    else $error("request taken right after clear");

  // the total never wraps, so it is nonzero exactly when data was counted
  a_total_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> has_data == (sample_total != '0))
    else $error("has_data disagrees with sample_total");

endmodule

bind subsampled_image_histogram ssih_check u_ssih_check (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (sample_in.valid),
  .in_ready     (sample_in.ready),
  .req_type     (sample_in.req_type),
  .out_valid    (result_out.valid),
  .out_ready    (result_out.ready),
  .sample_total (result_out.sample_total),
  .has_data     (result_out.has_data)
);

@@ sim/tb.sv @@
// tb: self-checking bench for subsampled_image_histogram; streams pixel, read and clear beats,
// predicts read responses from its histogram copy or the directed row; checks each field.
// Depends on ssih_pkg, ssih_if and the design files.
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0] REQ_NONE  = 2'd3;  // unused request code, ignored by the block
  localparam logic [1:0] FMT_SPARE = 2'd3;  // unused format code, behaves as RGB
  localparam logic [2:0] PFMT_ADDR = 3'd0;
  localparam int STEP       = 4;
  localparam int SETTLE_CYC = 300;          // covers a full clearing pass
  localparam int HOLD_CYC   = 400;
  localparam int PHASE_BEATS = 195;
  localparam int LIMIT      = 500000;

  typedef struct packed {
    logic [1:0]  req;
    logic [23:0] pix;
    logic        row_end;
    logic [7:0]  idx;
    logic        typed;   // response below is fixed, not predicted
    logic [31:0] cnt;
    logic [31:0] tot;
    logic        seen;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] cnt;
    logic [31:0] tot;
    logic        seen;
  } hist_read_t;

  localparam stim_row_t DIRECTED [0:23] = '{
    '{ssih_pkg::REQ_READ,  24'h000000, 1'b0, 8'h00, 1'b1, 32'd0, 32'd0, 1'b0},
    '{ssih_pkg::REQ_READ,  24'h000000, 1'b0, 8'hFF, 1'b1, 32'd0, 32'd0, 1'b0},
    '{ssih_pkg::REQ_PIXEL, 24'hFFFFFF, 1'b0, 8'h00, 1'b0, 32'd0, 32'd0, 1'b0},
    '{ssih_pkg::REQ_READ,  24'h000000, 1'b0, 8'hFF, 1'b1, 32'd1, 32'd1, 1'b1},
    '{ssih_pkg::REQ_PIXEL, 24'h000000, 1'b0, 8'h00, 1'b0, 32'd0, 32'd0, 1'b0},
    '{ssih_pkg::REQ_PIXEL, 24'h000000, 1'b0, 8'h00, 1'b0, 32'd0, 32'd0, 1'b0},
    '{ssih_pkg::REQ_PIXEL, 24'h000000, 1'b0, 8'h00, 1'b0, 32'd0, 32'd0, 1'b0},
    '{ssih_pkg::REQ_PIXEL, 24'h000000, 1'b1, 8'h00, 1'b0, 32'd0, 32'd0, 1'b0},
    '{ssih_pkg::REQ_READ,  24'h000000, 1'b0, 8'h00, 1'b1, 32'd1, 32'd2, 1'b1},
    '{ssih_pkg::REQ_PIXEL, 24'h0000AB, 1'b1, 8'h00, 1'b0, 32'd0, 32'd0, 1'b0},
    '{ssih_pkg::REQ_PIXEL, 24'h0000AB, 1'b1, 8'h00, 1'b0, 32'd0, 32'd0, 1'b0},
    '{ssih_pkg::REQ_PIXEL, 24'h0000AB, 1'b1, 8'h00, 1'b0, 32'd0, 32'd0, 1'b0},
    '{ssih_pkg::REQ_PIXEL, 24'h00FF80, 1'b0, 8'h00, 1'b0, 32'd0, 32'd0, 1'b0},
    '{ssih_pkg::REQ_READ,  24'h000000, 1'b0, 8'h80, 1'b0, 32'd0, 32'd0, 1'b0},
    '{REQ_NONE,            24'hFFFFFF, 1'b1, 8'hFF, 1'b0, 32'd0, 32'd0, 1'b0},
    '{ssih_pkg::REQ_READ,  24'h000000, 1'b0, 8'h80, 1'b0, 32'd0, 32'd0, 1'b0},
    '{ssih_pkg::REQ_PIXEL, 24'h000080, 1'b0, 8'h00, 1'b0, 32'd0, 32'd0, 1'b0},
    '{ssih_pkg::REQ_CLEAR, 24'h000000, 1'b0, 8'h00, 1'b0, 32'd0, 32'd0, 1'b0},
    '{ssih_pkg::REQ_READ,  24'h000000, 1'b0, 8'hFF, 1'b1, 32'd0, 32'd0, 1'b0},
    '{ssih_pkg::REQ_READ,  24'h000000, 1'b0, 8'h00, 1'b1, 32'd0, 32'd0, 1'b0},
    '{ssih_pkg::REQ_PIXEL, 24'hAAAA55, 1'b0, 8'h00, 1'b0, 32'd0, 32'd0, 1'b0},
    '{ssih_pkg::REQ_PIXEL, 24'h555555, 1'b0, 8'h00, 1'b0, 32'd0, 32'd0, 1'b0},
    '{ssih_pkg::REQ_READ,  24'h000000, 1'b0, 8'h55, 1'b1, 32'd1, 32'd1, 1'b1},
    '{ssih_pkg::REQ_READ,  24'h000000, 1'b0, 8'hAA, 1'b1, 32'd0, 32'd1, 1'b1}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  ssih_in_if  req_ch ();
  ssih_out_if res_ch ();

  subsampled_image_histogram uut (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (req_ch),
    .result_out (res_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // histogram shadow
  logic [31:0] bin_tally [256];
  logic [1:0]  col_ph, row_ph;
  logic [31:0] tally_total;
  logic        any_seen;
  logic [1:0]  fmt_shadow;

  hist_read_t pending [$];
  hist_read_t want;
  int errors = 0;
  int reads_checked = 0;
  int beats_sent = 0;
  int clears_sent = 0;
  int cycle_cnt = 0;
  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;

  function automatic void wipe_hist();
    foreach (bin_tally[i]) bin_tally[i] = '0;
    col_ph      = '0;
    row_ph      = '0;
    tally_total = '0;
    any_seen    = 1'b0;
  endfunction

  function automatic void apply_request(input stim_row_t r);
    logic [7:0] b;
    case (r.req)
      ssih_pkg::REQ_PIXEL: begin
        if (col_ph == 0 && row_ph == 0) begin
          b = (fmt_shadow == ssih_pkg::FMT_GRAY8) ? r.pix[7:0] : r.pix[15:8];
          if (bin_tally[b] != '1) bin_tally[b] = bin_tally[b] + 32'd1;
          if (tally_total != '1) tally_total = tally_total + 32'd1;
          any_seen = 1'b1;
        end
        if (r.row_end) begin
          col_ph = '0;
          row_ph = (row_ph == STEP - 1) ? 2'd0 : row_ph + 2'd1;
        end else begin
          col_ph = (col_ph == STEP - 1) ? 2'd0 : col_ph + 2'd1;
        end
      end
      ssih_pkg::REQ_READ: begin
        if (r.typed) pending.push_back('{r.cnt, r.tot, r.seen});
        else pending.push_back('{bin_tally[r.idx], tally_total, any_seen});
      end
      ssih_pkg::REQ_CLEAR: wipe_hist();
      default: ;
    endcase
  endfunction

  // one request beat, then maybe an idle burst
  task automatic send_row(input stim_row_t r);
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= r.req;
    req_ch.pixel_value <= r.pix;
    req_ch.last_in_row <= r.row_end;
    req_ch.bin_index   <= r.idx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    apply_request(r);
    if (r.req != REQ_NONE) beats_sent++;
    if (r.req == ssih_pkg::REQ_CLEAR) clears_sent++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_xfer(input logic wr, input logic [2:0] a, input logic [31:0] d,
                          output logic [31:0] q);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    q = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_format(input logic [1:0] f);
    logic [31:0] q;
    cfg_xfer(1'b0, PFMT_ADDR, 32'd0, q);
    if (q !== {30'd0, f}) begin
      errors++;
      $display("%0t: pixel_format readback expected %0d got %0d", $time, f, q);
    end
  endtask

  task automatic set_format(input logic [1:0] f);
    logic [31:0] q;
    drain();
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_xfer(1'b1, PFMT_ADDR, {30'd0, f}, q);
    fmt_shadow = f;
    check_format(f);
  endtask

  // result side: random stalls, plus one long hold on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
        if (hold_left == 0) hold_req = 1'b0;
      end else if (hold_req) begin
        hold_left = HOLD_CYC;
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall_left = int'($urandom_range(1, 14)) - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result beat with no read outstanding (count %0d total %0d)",
                 $time, res_ch.bin_count, res_ch.sample_total);
      end else begin
        want = pending.pop_front();
        reads_checked++;
        if (res_ch.bin_count !== want.cnt) begin
          errors++;
          $display("%0t: bin_count expected %0d got %0d", $time, want.cnt, res_ch.bin_count);
        end
        if (res_ch.sample_total !== want.tot) begin
          errors++;
          $display("%0t: sample_total expected %0d got %0d", $time, want.tot,
                   res_ch.sample_total);
        end
        if (res_ch.has_data !== want.seen) begin
          errors++;
          $display("%0t: has_data expected %0b got %0b", $time, want.seen, res_ch.has_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d reads outstanding", $time, cycle_cnt,
               pending.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [1:0] phase_fmt [5];
    logic [7:0] hot [4];
    stim_row_t row;
    logic [7:0] h;
    int n;
    int row_left;
    int pick;
    int read_pct;

    phase_fmt = '{ssih_pkg::FMT_GRAY16, ssih_pkg::FMT_RGB, FMT_SPARE, ssih_pkg::FMT_GRAY8,
                  ssih_pkg::FMT_RGB};
    hot = '{8'h00, 8'hFF, 8'h80, 8'h3C};
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= ssih_pkg::REQ_PIXEL;
    req_ch.pixel_value <= '0;
    req_ch.last_in_row <= 1'b0;
    req_ch.bin_index   <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    wipe_hist();
    fmt_shadow = ssih_pkg::FMT_GRAY8;
    row_left = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (SETTLE_CYC) @(posedge clk);  // clearing pass after reset
    check_format(ssih_pkg::FMT_GRAY8);

    foreach (DIRECTED[i]) send_row(DIRECTED[i]);

    for (int p = 0; p < 5; p++) begin
      set_format(phase_fmt[p]);
      if (p == 4) gaps_on = 1'b0;
      n = 0;
      while (n < PHASE_BEATS) begin
        if (p == 1 && n == 60) hold_req = 1'b1;
        if (p == 2 && n == 100) drain();
        read_pct = hold_req ? 50 : 25;
        pick = int'($urandom_range(0, 99));
        h = hot[$urandom_range(0, 3)];
        row = '0;
        row.pix = 24'($urandom_range(0, 24'hFFFFFF));
        row.idx = 8'($urandom_range(0, 255));
        if (pick < 3) begin
          row.req = ssih_pkg::REQ_CLEAR;
        end else if (pick < 5) begin
          row.req = REQ_NONE;
          row.row_end = 1'($urandom_range(0, 1));
        end else if (pick < 5 + read_pct) begin
          row.req = ssih_pkg::REQ_READ;
          // aim most reads at bins that are likely populated
          if ($urandom_range(0, 9) < 6) row.idx = h;
        end else begin
          row.req = ssih_pkg::REQ_PIXEL;
          if ($urandom_range(0, 1) == 0) row.pix[15:0] = {h, h};
          if (row_left == 0) row_left = int'($urandom_range(1, 16));
          row_left--;
          row.row_end = (row_left == 0);
          if ($urandom_range(0, 9) == 0) row.row_end = 1'($urandom_range(0, 1));  // broken rows
        end
        send_row(row);
        if (row.req != REQ_NONE) n++;
      end
    end

    drain();
    repeat (SETTLE_CYC) @(posedge clk);
    $display("%0d request beats incl. %0d clears, %0d read responses checked", beats_sent,
             clears_sent, reads_checked);
    $display("formats gray8/gray16/rgb/spare, random stalls, one long result hold");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ subsampled_image_histogram.f @@
design/ssih_pkg.sv
design/ssih_if.sv
design/ssih_ctrl.sv
design/ssih_datapath.sv
design/subsampled_image_histogram.sv
design/ssih_check.sv
sim/tb.sv
